// ===== rtl/sfh_pkg.sv =====
// Shared types and mixing functions for the streaming string hash.
// Used by sfh_accum, sfh_final and the top level superfast_string_hash.
// No dependencies.
package sfh_pkg;

  // Count of held bytes, 0 to 3.
  typedef logic [1:0] cnt_t;

  // Codes for the number of leftover bytes at the end of a message.
  localparam cnt_t CntNone  = 2'd0;
  localparam cnt_t CntOne   = 2'd1;
  localparam cnt_t CntTwo   = 2'd2;
  localparam cnt_t CntThree = 2'd3;

  // Snapshot of a finished message, handed from the accumulator to the finisher.
  typedef struct packed {
    logic [31:0] acc;
    logic [23:0] held;
    cnt_t        cnt;
  } fin_item_t;

  // Sign-extend one byte to 32 bits, as a signed char would be.
  function automatic logic [31:0] sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction

  // Main round over one group of four bytes split into two 16-bit halves.
  function automatic logic [31:0] main_round(input logic [31:0] h_in,
                                             input logic [15:0] lo,
                                             input logic [15:0] hi);
    logic [31:0] h;
    logic [31:0] t;
    h = h_in + {16'd0, lo};
    t = ({16'd0, hi} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    main_round = h;
  endfunction

  // Tail rule for the one to three bytes left over at the end.
  function automatic logic [31:0] tail_mix(input logic [31:0] h_in,
                                           input logic [23:0] held,
                                           input cnt_t        cnt);
    logic [31:0] h;
    h = h_in;
    case (cnt)
      CntThree: begin
        h = h + {16'd0, held[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(held[23:16]) << 18);
        h = h + (h >> 11);
      end
      CntTwo: begin
        h = h + {16'd0, held[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      CntOne: begin
        h = h + sext8(held[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    tail_mix = h;
  endfunction

  // First half of the avalanche: three steps.
  function automatic logic [31:0] aval_lo(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    aval_lo = h;
  endfunction

  // Second half of the avalanche: the remaining three steps.
  function automatic logic [31:0] aval_hi(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    aval_hi = h;
  endfunction

endpackage

// ===== rtl/superfast_string_hash.sv =====
// Streaming 32-bit string hash, one message byte per word on the input channel.
// Top level; instantiates sfh_accum and sfh_final. Depends on sfh_pkg.
//
// Input channel: one message byte per word in in_tdata; in_tlast marks the
// final byte of a message; in_tuser set means an empty message (the byte is
// ignored, any bytes of a message in progress are dropped, and the hash is 0).
// Output channel: one word per message on out_tdata, the 32-bit hash.
// Throughput: one input word every cycle while in_tready is high; a new message
// may start on the cycle after the previous last byte. Every four bytes a main
// round runs in the same cycle that takes the fourth byte.
// The snapshot register loads on the edge that accepts the last byte; then the
// tail register and the two avalanche registers load in turn, and the hash
// appears on out_tvalid from the last of them.
// Reset: rst_n low for one clock clears the hash state and all pipeline valid
// flags; no output word is pending afterwards.
// Stall: when out_tready is low the pipeline fills up and holds its words;
// in_tready falls only once the snapshot register is held as well. Non-final
// bytes are taken whenever in_tready is high.
module superfast_string_hash import sfh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] empty_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] hash_value
);

  logic      fin_valid;
  logic      fin_ready;
  fin_item_t fin_item;

  // Byte gathering and running state.
  sfh_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (in_tvalid),
    .byte_ready    (in_tready),
    .data_byte     (in_tdata),
    .last_byte     (in_tlast),
    .empty_message (in_tuser),
    .fin_valid     (fin_valid),
    .fin_ready     (fin_ready),
    .fin_item      (fin_item)
  );

  // Tail rule and avalanche, ending in the output register.
  sfh_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready),
    .fin_item   (fin_item),
    .hash_valid (out_tvalid),
    .hash_ready (out_tready),
    .hash_value (out_tdata)
  );

endmodule

// ===== rtl/sfh_accum.sv =====
// Byte gathering and main mixing rounds; holds the running hash state.
// Emits one finished-message snapshot per message. Depends on sfh_pkg.
module sfh_accum import sfh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       empty_message,
  output logic       fin_valid,
  input  logic       fin_ready,
  output fin_item_t  fin_item
);

  logic [31:0] acc_r, acc_nxt;
  logic [23:0] held_r, held_nxt;
  cnt_t        cnt_r, cnt_nxt;
  logic        fin_valid_r, fin_valid_nxt;
  fin_item_t   fin_r, fin_nxt;
  logic        accept;
  logic        emit;
  logic [31:0] acc_upd;
  logic [23:0] held_upd;
  cnt_t        cnt_upd;

  // The snapshot register frees up whenever the finisher takes its word.
  assign byte_ready = !fin_valid_r || fin_ready;
  assign accept     = byte_valid && byte_ready;
  assign emit       = accept && (last_byte || empty_message);

  // Fold in the byte, or run a main round on a full group; empty clears the state.
  always_comb begin
    acc_upd  = acc_r;
    held_upd = held_r;
    cnt_upd  = cnt_r + 2'd1;
    case (cnt_r)
      CntNone:  held_upd[7:0]   = data_byte;
      CntOne:   held_upd[15:8]  = data_byte;
      CntTwo:   held_upd[23:16] = data_byte;
      CntThree: begin
        acc_upd  = main_round(acc_r, held_r[15:0], {data_byte, held_r[23:16]});
        held_upd = '0;
        cnt_upd  = CntNone;
      end
      default: begin
        held_upd = held_r;
      end
    endcase
    if (empty_message) begin
      acc_upd  = '0;
      held_upd = '0;
      cnt_upd  = CntNone;
    end
  end

  // Next state; a finished or empty message returns the state to its reset values.
  always_comb begin
    acc_nxt       = acc_r;
    held_nxt      = held_r;
    cnt_nxt       = cnt_r;
    fin_nxt       = fin_r;
    fin_valid_nxt = fin_valid_r && !fin_ready;
    if (accept) begin
      acc_nxt  = acc_upd;
      held_nxt = held_upd;
      cnt_nxt  = cnt_upd;
    end
    if (emit) begin
      fin_nxt.acc   = acc_upd;
      fin_nxt.held  = held_upd;
      fin_nxt.cnt   = cnt_upd;
      fin_valid_nxt = 1'b1;
      acc_nxt       = '0;
      held_nxt      = '0;
      cnt_nxt       = CntNone;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      held_r      <= '0;
      cnt_r       <= CntNone;
      fin_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      fin_valid_r <= fin_valid_nxt;
    end
  end

  // Snapshot payload needs no reset.
  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

  assign fin_valid = fin_valid_r;
  assign fin_item  = fin_r;

endmodule

// ===== rtl/sfh_final.sv =====
// Finishing pipeline: tail rule, then the avalanche over two stages.
// The last stage is the output register. Depends on sfh_pkg.
module sfh_final import sfh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fin_valid,
  output logic        fin_ready,
  input  fin_item_t   fin_item,
  output logic        hash_valid,
  input  logic        hash_ready,
  output logic [31:0] hash_value
);

  logic        v1_r, v2_r, v3_r;
  logic [31:0] h1_r, h2_r, h3_r;
  logic        load1, load2, load3;
  logic        free1, free2, free3;

  // Each stage moves on when the stage after it is empty or emptying.
  assign free3 = !v3_r || hash_ready;
  assign load3 = v2_r && free3;
  assign free2 = !v2_r || load3;
  assign load2 = v1_r && free2;
  assign free1 = !v1_r || load2;
  assign load1 = fin_valid && free1;

  assign fin_ready = free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (free1) begin
        v1_r <= fin_valid;
      end
      if (free2) begin
        v2_r <= v1_r;
      end
      if (free3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage data: tail rule, first avalanche half, second avalanche half.
  always_ff @(posedge clk) begin
    if (load1) begin
      h1_r <= tail_mix(fin_item.acc, fin_item.held, fin_item.cnt);
    end
    if (load2) begin
      h2_r <= aval_lo(h1_r);
    end
    if (load3) begin
      h3_r <= aval_hi(h2_r);
    end
  end

  assign hash_valid = v3_r;
  assign hash_value = h3_r;

endmodule

// ===== dv/superfast_string_hash_test.sv =====
// Self-checking testbench for superfast_string_hash: byte streams in, one hash word out per message.
// A directed table runs first, then random messages with random idling and stalls on both channels.
// Depends on sfh_pkg and the superfast_string_hash RTL.
module superfast_string_hash_test;
  import sfh_pkg::*;

  localparam int NumProbes   = 23;
  localparam int RandomWords = 800;
  localparam int HoldCycles  = 160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  // Running copy of the hash state, advanced as each input word is accepted.
  logic [31:0] run_acc = '0;
  logic [23:0] run_held = '0;
  cnt_t        run_cnt = CntNone;

  logic [31:0] hash_expected [$];
  int          fail_count = 0;
  int          words_sent = 0;
  int          holds_asked = 0;
  bit          quiet = 1'b0;

  // One row of the directed table; where fixed is set the hash is typed in.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        empty;
    logic        fixed;
    logic [31:0] fixed_hash;
  } probe_t;

  probe_t probes [0:NumProbes-1] = '{
    // Empty message straight after reset, then with a byte and a last flag to ignore.
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'h0},
    '{8'hff, 1'b1, 1'b1, 1'b1, 32'h0},
    // Single bytes: a zero byte hashes to zero; the others exercise sign extension.
    '{8'h00, 1'b1, 1'b0, 1'b1, 32'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    // Two and three leftover bytes, the third one negative.
    '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h02, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    // One full group with no leftover bytes.
    '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    // Empty flag in the middle of a message drops the held bytes.
    '{8'h12, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h34, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h56, 1'b0, 1'b1, 1'b1, 32'h0},
    // A full group followed by one leftover byte.
    '{8'ha0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'hb1, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'hc2, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'hd3, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'he4, 1'b1, 1'b0, 1'b0, 32'h0}
  };

  superfast_string_hash u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Advance the running hash by one word; returns 1 when the word finishes a message.
  function automatic bit predict_hash(input logic [7:0] b, input logic last,
                                      input logic empty, output logic [31:0] hash);
    logic [31:0] h;
    logic [31:0] mix;
    hash = '0;
    if (empty) begin
      run_acc  = '0;
      run_held = '0;
      run_cnt  = CntNone;
      return 1'b1;
    end
    // The fourth byte of a group completes the main round.
    if (run_cnt == CntThree) begin
      h        = run_acc + {16'd0, run_held[15:0]};
      mix      = ({16'd0, b, run_held[23:16]} << 11) ^ h;
      h        = (h << 16) ^ mix;
      run_acc  = h + (h >> 11);
      run_held = '0;
      run_cnt  = CntNone;
    end else begin
      run_held[8*run_cnt +: 8] = b;
      run_cnt = run_cnt + 2'd1;
    end
    if (!last) begin
      return 1'b0;
    end
    // Tail rule for the leftover bytes, each single byte taken as signed.
    h = run_acc;
    case (run_cnt)
      CntThree: begin
        h = h + {16'd0, run_held[15:0]};
        h = h ^ (h << 16);
        h = h ^ ({{24{run_held[23]}}, run_held[23:16]} << 18);
        h = h + (h >> 11);
      end
      CntTwo: begin
        h = h + {16'd0, run_held[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      CntOne: begin
        h = h + {{24{run_held[7]}}, run_held[7:0]};
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
      end
    endcase
    // Final avalanche.
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    hash     = h;
    run_acc  = '0;
    run_held = '0;
    run_cnt  = CntNone;
    return 1'b1;
  endfunction

  // Offer one word, possibly after a few idle cycles, and record its hash once taken.
  task automatic send_word(input logic [7:0] b, input logic last, input logic empty,
                           input logic fixed, input logic [31:0] fixed_hash);
    logic [31:0] hash;
    bit          finished;
    while (!quiet && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    in_tuser  <= empty;
    do begin
      @(posedge clk);
    end while (!in_tready);
    finished = predict_hash(b, last, empty, hash);
    if (finished) begin
      hash_expected.push_back(fixed ? fixed_hash : hash);
    end
    words_sent++;
    @(negedge clk);
  endtask

  // Stop offering words until every outstanding hash has come back.
  task automatic drain_hashes();
    in_tvalid <= 1'b0;
    wait (hash_expected.size() == 0);
    @(negedge clk);
  endtask

  // Receiver: random back-pressure, plus long hold-offs on request, counted here.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  // Compare every accepted hash word with the oldest prediction.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_expected.size() == 0) begin
        $error("hash_value: expected no word, actual %h", out_tdata);
        fail_count++;
      end else begin
        want = hash_expected.pop_front();
        if (out_tdata !== want) begin
          $error("hash_value: expected %h, actual %h", want, out_tdata);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random messages.
  initial begin : stimulus
    int          length;
    int          kind;
    int          random_start;
    bit          held_off;
    bit          paused;
    logic [7:0]  b;
    logic [31:0] drop;
    held_off = 1'b0;
    paused   = 1'b0;
    drop     = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (probes[i]) begin
      send_word(probes[i].data, probes[i].last, probes[i].empty,
                probes[i].fixed, probes[i].fixed_hash);
    end
    drain_hashes();

    random_start = words_sent;
    while (words_sent - random_start < RandomWords) begin
      // Long receiver hold-off while words keep coming, then a full drain later on.
      if (!held_off && words_sent - random_start > 250) begin
        held_off = 1'b1;
        holds_asked++;
      end
      if (!paused && words_sent - random_start > 450) begin
        paused = 1'b1;
        drain_hashes();
      end
      quiet = (words_sent - random_start > 550) && (words_sent - random_start < 680);

      kind   = $urandom_range(99);
      length = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(48, 13);
      if (kind < 5) begin
        // Empty message, with random byte and last flag that must be ignored.
        send_word(8'($urandom), 1'($urandom), 1'b1, 1'b0, drop);
      end else begin
        for (int n = 0; n < length; n++) begin
          b = ($urandom_range(99) < 15) ? 8'(8'h7f + $urandom_range(1)) ^ {8{$urandom_range(1) == 1}}
                                        : 8'($urandom);
          // Broken messages are cut short by an empty flag on their final word.
          if (kind < 12 && n == length - 1) begin
            send_word(b, 1'($urandom), 1'b1, 1'b0, drop);
          end else begin
            send_word(b, n == length - 1, 1'b0, 1'b0, drop);
          end
        end
      end
    end
    quiet = 1'b0;
    drain_hashes();
    repeat (16) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
